/* sv/oli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oli_pkg
// Shared types, codes and defaults for the ordered list insert block.
// ----------------------------------------------------------------------------
package oli_pkg;

  // Default list depth
  localparam int CAPACITY_DEF = 16;

  // Fixed payload widths
  localparam int CMD_W         = 2;
  localparam int VALUE_W       = 32;
  localparam int POSITION_W    = 8;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_INDEX_W = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INS_END   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READOUT   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_ins;    // load insert result, insert on ok status
    logic ld_empty;  // load empty readout result
    logic ld_entry;  // load front entry, rotate list, advance index
    logic clr_idx;   // restart the readout index
  } oli_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic list_empty;
    logic rd_last;
  } oli_sts_t;

endpackage

/* sv/oli_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oli_ctrl
// Controller: input handshake, output valid register and readout sequencing.
// ----------------------------------------------------------------------------
module oli_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [oli_pkg::CMD_W-1:0]    in_cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output oli_pkg::oli_cmd_t            dp_cmd,
  input  oli_pkg::oli_sts_t            dp_sts
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_STREAM = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  logic in_acc;

  // Output slot can take a new beat when empty or being drained
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Sequence commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dp_cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == oli_pkg::CMD_READOUT) begin
            if (dp_sts.list_empty) begin
              dp_cmd.ld_empty = 1'b1;
              out_valid_nxt   = 1'b1;
            end else begin
              dp_cmd.clr_idx = 1'b1;
              state_nxt      = S_STREAM;
            end
          end else begin
            dp_cmd.ld_ins = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_STREAM: begin
        if (slot_free) begin
          dp_cmd.ld_entry = 1'b1;
          out_valid_nxt   = 1'b1;
          if (dp_sts.rd_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/oli_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oli_dp
// Datapath: shifting row of list cells, entry count, readout index and the
// result payload register.
// ----------------------------------------------------------------------------
module oli_dp #(
  parameter int CAPACITY = oli_pkg::CAPACITY_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [oli_pkg::CMD_W-1:0]               in_cmd,
  input  logic signed [oli_pkg::VALUE_W-1:0]      in_value,
  input  logic [oli_pkg::POSITION_W-1:0]          in_position,
  input  oli_pkg::oli_cmd_t                       dp_cmd,
  output oli_pkg::oli_sts_t                       dp_sts,
  output logic [oli_pkg::STATUS_W-1:0]            out_status,
  output logic signed [oli_pkg::VALUE_W-1:0]      out_entry_value,
  output logic [oli_pkg::ENTRY_INDEX_W-1:0]       out_entry_index,
  output logic                                    out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic signed [oli_pkg::VALUE_W-1:0] cell_r   [CAPACITY];
  logic signed [oli_pkg::VALUE_W-1:0] cell_nxt [CAPACITY];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] last_pos;

  logic [oli_pkg::STATUS_W-1:0]         status_r, status_nxt;
  logic signed [oli_pkg::VALUE_W-1:0]   value_r, value_nxt;
  logic [oli_pkg::ENTRY_INDEX_W-1:0]    index_r, index_nxt;
  logic                                 last_r, last_nxt;

  logic                         full;
  logic [oli_pkg::POSITION_W-1:0] pos_m1;
  logic [oli_pkg::STATUS_W-1:0] ins_status;
  logic [IDX_W-1:0]             ins_slot;
  logic                         do_insert;

  assign full     = (count_r == CNT_W'(CAPACITY));
  assign last_pos = count_r - CNT_W'(1);
  assign pos_m1   = in_position - oli_pkg::POSITION_W'(1);

  assign dp_sts.list_empty = (count_r == '0);
  assign dp_sts.rd_last    = (CNT_W'(rd_idx_r) == last_pos);

  // Decide insert slot and status
  always_comb begin
    ins_status = oli_pkg::ST_OK;
    ins_slot   = '0;
    if (full) begin
      ins_status = oli_pkg::ST_FULL;
    end else begin
      case (in_cmd)
        oli_pkg::CMD_INS_FRONT: ins_slot = '0;
        oli_pkg::CMD_INS_END:   ins_slot = count_r[IDX_W-1:0];
        oli_pkg::CMD_INS_POS: begin
          if (in_position <= oli_pkg::POSITION_W'(1)) begin
            ins_slot = '0;
          end else if (pos_m1 <= oli_pkg::POSITION_W'(count_r)) begin
            ins_slot = pos_m1[IDX_W-1:0];
          end else begin
            ins_status = oli_pkg::ST_BAD_POS;
          end
        end
        default: ins_status = oli_pkg::ST_OK;
      endcase
    end
  end

  assign do_insert = dp_cmd.ld_ins && (ins_status == oli_pkg::ST_OK);

  // Shift cells back behind the slot on insert; rotate the used part on readout
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_insert) begin
        if (IDX_W'(i) == ins_slot) begin
          cell_nxt[i] = in_value;
        end else if ((i > 0) && (IDX_W'(i) > ins_slot)) begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end
      end else if (dp_cmd.ld_entry) begin
        if (CNT_W'(i) == last_pos) begin
          cell_nxt[i] = cell_r[0];
        end else if ((i < CAPACITY - 1) && (CNT_W'(i) < last_pos)) begin
          cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Count and readout index
  always_comb begin
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (dp_cmd.clr_idx) begin
      rd_idx_nxt = '0;
    end else if (dp_cmd.ld_entry) begin
      rd_idx_nxt = rd_idx_r + IDX_W'(1);
    end
  end

  // Load the result beat
  always_comb begin
    status_nxt = status_r;
    value_nxt  = value_r;
    index_nxt  = index_r;
    last_nxt   = last_r;
    if (dp_cmd.ld_ins) begin
      status_nxt = ins_status;
      value_nxt  = '0;
      index_nxt  = '0;
      last_nxt   = 1'b1;
    end else if (dp_cmd.ld_empty) begin
      status_nxt = oli_pkg::ST_EMPTY;
      value_nxt  = '0;
      index_nxt  = '0;
      last_nxt   = 1'b1;
    end else if (dp_cmd.ld_entry) begin
      status_nxt = oli_pkg::ST_OK;
      value_nxt  = cell_r[0];
      index_nxt  = oli_pkg::ENTRY_INDEX_W'(rd_idx_r);
      last_nxt   = dp_sts.rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    rd_idx_r <= rd_idx_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
    index_r  <= index_nxt;
    last_r   <= last_nxt;
  end

  assign out_status      = status_r;
  assign out_entry_value = value_r;
  assign out_entry_index = index_r;
  assign out_last        = last_r;

endmodule

/* sv/ordered_list_insert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert
// Ordered list of signed 32-bit values with positional insert and readout.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY registers that all shift back behind
// the insert slot together. An insert command gives one status beat; the
// next item is taken as soon as that beat is taken or in the same cycle. A
// readout gives count beats at one per cycle while the receiver does not
// stall, front to back, by rotating the used cells through the front
// register; the list is back in order after the last beat. An empty list
// reads out as one empty-status beat. No item is taken during a readout.
module ordered_list_insert #(
  parameter int CAPACITY = oli_pkg::CAPACITY_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [oli_pkg::CMD_W-1:0]               in_cmd,
  input  logic signed [oli_pkg::VALUE_W-1:0]      in_value,
  input  logic [oli_pkg::POSITION_W-1:0]          in_position,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [oli_pkg::STATUS_W-1:0]            out_status,
  output logic signed [oli_pkg::VALUE_W-1:0]      out_entry_value,
  output logic [oli_pkg::ENTRY_INDEX_W-1:0]       out_entry_index,
  output logic                                    out_last
);

  oli_pkg::oli_cmd_t dp_cmd;
  oli_pkg::oli_sts_t dp_sts;

  // Control
  oli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  // List storage and result payload
  oli_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .in_position     (in_position),
    .dp_cmd          (dp_cmd),
    .dp_sts          (dp_sts),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_entry_index (out_entry_index),
    .out_last        (out_last)
  );

endmodule

/* dv/ordered_list_insert_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_tb
// Self-checking bench for the ordered list insert block. A directed table
// walks the list from empty to full through every command and rejection,
// then random commands run under three stall profiles. Every result beat is
// compared field by field with a queue-based model of the list.
// ----------------------------------------------------------------------------
module ordered_list_insert_tb;

  localparam int CAPACITY    = oli_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 304;
  localparam int N_DIR       = 26;
  localparam int TAIL_CYCLES = 16;

  // One result beat as it leaves the block
  typedef struct packed {
    logic [oli_pkg::STATUS_W-1:0]        status;
    logic signed [oli_pkg::VALUE_W-1:0]  entry_value;
    logic [oli_pkg::ENTRY_INDEX_W-1:0]   entry_index;
    logic                                last;
  } list_beat_t;

  // One directed command; has_status marks a status typed in by hand
  typedef struct packed {
    logic [oli_pkg::CMD_W-1:0]           cmd;
    logic signed [oli_pkg::VALUE_W-1:0]  value;
    logic [oli_pkg::POSITION_W-1:0]      position;
    logic                                has_status;
    logic [oli_pkg::STATUS_W-1:0]        status;
  } list_op_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic [oli_pkg::CMD_W-1:0]             in_cmd = oli_pkg::CMD_INS_FRONT;
  logic signed [oli_pkg::VALUE_W-1:0]    in_value = '0;
  logic [oli_pkg::POSITION_W-1:0]        in_position = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic [oli_pkg::STATUS_W-1:0]          out_status;
  logic signed [oli_pkg::VALUE_W-1:0]    out_entry_value;
  logic [oli_pkg::ENTRY_INDEX_W-1:0]     out_entry_index;
  logic                                  out_last;

  // Hand-typed status riding along with the command beat
  logic                                  op_has_status = 1'b0;
  logic [oli_pkg::STATUS_W-1:0]          op_status = oli_pkg::ST_OK;

  int                                    send_idle_pct = 10;
  int                                    recv_idle_pct = 78;
  int                                    cycle_count = 0;
  int                                    errors = 0;
  int                                    ops_taken = 0;
  int                                    readouts_taken = 0;
  int                                    beats_checked = 0;

  logic signed [oli_pkg::VALUE_W-1:0]    list_model[$];
  list_beat_t                            pending_beats[$];

  // Walk from empty to full: rejections, extremes, front, middle, append
  list_op_t dir_ops [N_DIR] = '{
    '{oli_pkg::CMD_READOUT,   32'h0000_0000, 8'd0,   1'b1, oli_pkg::ST_EMPTY},
    '{oli_pkg::CMD_INS_POS,   32'h0000_0011, 8'd2,   1'b1, oli_pkg::ST_BAD_POS},
    '{oli_pkg::CMD_INS_POS,   32'h0000_0022, 8'd255, 1'b1, oli_pkg::ST_BAD_POS},
    '{oli_pkg::CMD_INS_POS,   32'h7FFF_FFFF, 8'd0,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_FRONT, 32'h8000_0000, 8'd0,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_POS,   32'hFFFF_FFFF, 8'd1,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_END,   32'h0000_0000, 8'd0,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_POS,   32'h1234_5678, 8'd5,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_POS,   32'h0000_0001, 8'd3,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_POS,   32'h0000_0033, 8'd8,   1'b1, oli_pkg::ST_BAD_POS},
    '{oli_pkg::CMD_READOUT,   32'hFFFF_FFFF, 8'hFF,  1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_POS,   32'hA5A5_A5A5, 8'd7,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_END,   32'h5A5A_5A5A, 8'd0,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_FRONT, 32'h0001_0000, 8'd0,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_POS,   32'hFFFF_0000, 8'd4,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_POS,   32'h0000_FFFF, 8'd11,  1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_FRONT, 32'h7FFF_FFFE, 8'd0,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_END,   32'h8000_0001, 8'd0,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_POS,   32'hDEAD_BEEF, 8'd2,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_POS,   32'h0000_0044, 8'd16,  1'b1, oli_pkg::ST_BAD_POS},
    '{oli_pkg::CMD_INS_END,   32'h00C0_FFEE, 8'd0,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_POS,   32'hCAFE_F00D, 8'd9,   1'b0, oli_pkg::ST_OK},
    '{oli_pkg::CMD_INS_FRONT, 32'h0000_0055, 8'd0,   1'b1, oli_pkg::ST_FULL},
    '{oli_pkg::CMD_INS_POS,   32'h0000_0066, 8'd255, 1'b1, oli_pkg::ST_FULL},
    '{oli_pkg::CMD_INS_END,   32'h0000_0077, 8'd0,   1'b1, oli_pkg::ST_FULL},
    '{oli_pkg::CMD_READOUT,   32'h0000_0000, 8'd0,   1'b0, oli_pkg::ST_OK}
  };

  ordered_list_insert #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_entry_value(out_entry_value),
    .out_entry_index(out_entry_index),
    .out_last(out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one command to the list model and return the beats it should give
  function automatic void list_apply(input logic [oli_pkg::CMD_W-1:0] cmd,
                                     input logic signed [oli_pkg::VALUE_W-1:0] value,
                                     input logic [oli_pkg::POSITION_W-1:0] position,
                                     output list_beat_t beats[$]);
    int slot;
    int depth;
    beats = {};
    depth = list_model.size();
    if (cmd == oli_pkg::CMD_READOUT) begin
      if (depth == 0) begin
        beats.push_back('{oli_pkg::ST_EMPTY, '0, '0, 1'b1});
      end else begin
        for (int i = 0; i < depth; i++)
          beats.push_back('{oli_pkg::ST_OK, list_model[i],
                            oli_pkg::ENTRY_INDEX_W'(i), i == depth - 1});
      end
      return;
    end
    // full check wins over the position check
    if (depth >= CAPACITY) begin
      beats.push_back('{oli_pkg::ST_FULL, '0, '0, 1'b1});
      return;
    end
    if (cmd == oli_pkg::CMD_INS_FRONT) begin
      slot = 0;
    end else if (cmd == oli_pkg::CMD_INS_END) begin
      slot = depth;
    end else if (position <= 1) begin
      slot = 0;
    end else if (int'(position) - 1 <= depth) begin
      slot = int'(position) - 1;
    end else begin
      beats.push_back('{oli_pkg::ST_BAD_POS, '0, '0, 1'b1});
      return;
    end
    list_model.insert(slot, value);
    beats.push_back('{oli_pkg::ST_OK, '0, '0, 1'b1});
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: beat %0d %s mismatch, expected %0h, got %0h",
               $time, beats_checked, name, want, got);
    end
  endtask

  // Predict on every command beat, check every result beat
  always @(posedge clk) begin : track_beats
    list_beat_t fresh[$];
    list_beat_t got;
    list_beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        list_apply(in_cmd, in_value, in_position, fresh);
        if (op_has_status)
          pending_beats.push_back('{op_status, '0, '0, 1'b1});
        else
          foreach (fresh[k]) pending_beats.push_back(fresh[k]);
        ops_taken++;
        if (in_cmd == oli_pkg::CMD_READOUT) readouts_taken++;
      end
      if (out_valid && out_ready) begin
        got = '{out_status, out_entry_value, out_entry_index, out_last};
        if (pending_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, got %p", $time, got);
        end else begin
          want = pending_beats.pop_front();
          report_field("status", 32'(want.status), 32'(got.status));
          report_field("entry_value", want.entry_value, got.entry_value);
          report_field("entry_index", 32'(want.entry_index), 32'(got.entry_index));
          report_field("last", 32'(want.last), 32'(got.last));
        end
        beats_checked++;
      end
    end
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, pending_beats.size());
      $display("ordered_list_insert_tb: FAIL");
      $finish;
    end
  end

  // Present one command, hold it until taken, then maybe idle
  task automatic send_op(input logic [oli_pkg::CMD_W-1:0] cmd,
                         input logic signed [oli_pkg::VALUE_W-1:0] value,
                         input logic [oli_pkg::POSITION_W-1:0] position,
                         input logic has_status,
                         input logic [oli_pkg::STATUS_W-1:0] status);
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_value      <= value;
    in_position   <= position;
    op_has_status <= has_status;
    op_status     <= status;
    do @(posedge clk); while (!(in_valid && in_ready));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Drop valid and wait for every expected beat
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  initial begin : drive_ops
    logic [oli_pkg::CMD_W-1:0]          cmd;
    logic signed [oli_pkg::VALUE_W-1:0] value;
    logic [oli_pkg::POSITION_W-1:0]     position;
    int                                 pick;
    wait (rst_n === 1'b1);
    @(posedge clk);

    foreach (dir_ops[r])
      send_op(dir_ops[r].cmd, dir_ops[r].value, dir_ops[r].position,
              dir_ops[r].has_status, dir_ops[r].status);
    hold_until_drained();

    // Random commands under three stall profiles
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 78;
        recv_idle_pct = 10;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < RAND_ITEMS / 3; n++) begin
        value = $urandom;
        if ($urandom_range(15) == 0) begin
          case ($urandom_range(3))
            0: value = 32'h7FFF_FFFF;
            1: value = 32'h8000_0000;
            2: value = 32'h0000_0000;
            default: value = 32'hFFFF_FFFF;
          endcase
        end
        position = $urandom_range(255);
        pick = $urandom_range(99);
        if (pick < 40) begin
          cmd = oli_pkg::CMD_READOUT;
        end else if (pick < 88) begin
          cmd = oli_pkg::CMD_INS_POS;
        end else begin
          // well-formed insert at front, end or a legal position
          case ($urandom_range(2))
            0: cmd = oli_pkg::CMD_INS_FRONT;
            1: cmd = oli_pkg::CMD_INS_END;
            default: begin
              cmd = oli_pkg::CMD_INS_POS;
              position = $urandom_range(list_model.size() + 1);
            end
          endcase
        end
        send_op(cmd, value, position, 1'b0, oli_pkg::ST_OK);
      end
      hold_until_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d commands (%0d readouts), %0d result beats checked,",
             ops_taken, readouts_taken, beats_checked);
    $display("list held %0d of %0d entries at the end", list_model.size(), CAPACITY);
    if (errors == 0) begin
      $display("ordered_list_insert_tb: PASS");
    end else begin
      $display("ordered_list_insert_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
sv/oli_pkg.sv
sv/oli_ctrl.sv
sv/oli_dp.sv
sv/ordered_list_insert.sv
dv/ordered_list_insert_tb.sv
